// File: rtl/vao_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vao_pkg
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vao_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_W         = 15;
  localparam int MINLEN_W        = 16;
  localparam int STEPS           = 24;
  localparam int CW              = 64;   // CORDIC datapath width
  localparam int ZW              = 29;   // angle accumulator, Q20 degrees, signed
  localparam int NORM_BIT        = 58;
  localparam logic [ANGLE_W-1:0] ANGLE_DEGEN = 15'd23040;
  localparam logic signed [ZW-1:0] DEG_90  = 29'sd94371840;
  localparam logic signed [ZW-1:0] DEG_180 = 29'sd188743680;

  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 29'sd47185920;
      5'd1:  v = 29'sd27855475;
      5'd2:  v = 29'sd14718068;
      5'd3:  v = 29'sd7471121;
      5'd4:  v = 29'sd3750058;
      5'd5:  v = 29'sd1876857;
      5'd6:  v = 29'sd938658;
      5'd7:  v = 29'sd469357;
      5'd8:  v = 29'sd234682;
      5'd9:  v = 29'sd117342;
      5'd10: v = 29'sd58671;
      5'd11: v = 29'sd29335;
      5'd12: v = 29'sd14668;
      5'd13: v = 29'sd7334;
      5'd14: v = 29'sd3667;
      5'd15: v = 29'sd1833;
      5'd16: v = 29'sd917;
      5'd17: v = 29'sd458;
      5'd18: v = 29'sd229;
      5'd19: v = 29'sd115;
      5'd20: v = 29'sd57;
      5'd21: v = 29'sd29;
      5'd22: v = 29'sd14;
      5'd23: v = 29'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 degen;
  } cordic_t;

endpackage

// File: rtl/vao_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vao_in_if / vao_out_if
// Valid/ready channels for point triples and angle results.
// ----------------------------------------------------------------------------
interface vao_in_if #(parameter int COORD_WIDTH = vao_pkg::COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] arm1_x, arm1_y, vertex_x, vertex_y, arm2_x, arm2_y;
  modport source (output valid, arm1_x, arm1_y, vertex_x, vertex_y, arm2_x, arm2_y,
                  input ready);
  modport sink (input valid, arm1_x, arm1_y, vertex_x, vertex_y, arm2_x, arm2_y,
                output ready);
endinterface

interface vao_out_if;
  logic valid;
  logic ready;
  logic [vao_pkg::ANGLE_W-1:0] angle_degrees;
  logic degenerate;
  modport source (output valid, angle_degrees, degenerate, input ready);
  modport sink (input valid, angle_degrees, degenerate, output ready);
endinterface

// File: rtl/vertex_angle_of_three_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_angle_of_three_points
// Unsigned angle at a vertex from three 2-D points, pipelined CORDIC.
// ----------------------------------------------------------------------------
// Usage: a point triple (arm1, vertex, arm2) is requested on in_*; one result
// (angle in degrees with 7 fraction bits, degenerate flag) leaves on out_*.
// Pipeline: differences, products, sums, normalise (4 stages of shift
// search, 32/16/8/4 then 2/1, coarse to fine), 24 CORDIC stages, rounding.
// One request is taken per cycle while the receiver does not stall.
// cfg_we writes min_length_squared (reset 1); write only while idle.
// Reset clears all valid bits. When the receiver stalls the whole pipe holds
// (in_ready follows out_ready or an empty output slot); nothing is dropped.
// ----------------------------------------------------------------------------
module vertex_angle_of_three_points #(
  parameter int COORD_WIDTH = vao_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                         cfg_we,
  input  logic [vao_pkg::MINLEN_W-1:0] cfg_wdata,
  vao_in_if.sink                       in_ch,
  vao_out_if.source                    out_ch
);
  localparam int CW = vao_pkg::CW;
  localparam int DS = (COORD_WIDTH > 16) ? COORD_WIDTH - 16 : 0;
  localparam int LS = (COORD_WIDTH < 16) ? 2 * (16 - COORD_WIDTH) : 0;
  localparam int DW = 17;

  logic [vao_pkg::MINLEN_W-1:0] minlen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) minlen_r <= 16'd1;
    else if (cfg_we) minlen_r <= cfg_wdata;
  end

  // pipe advances unless the output holds an untaken result
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: arm vectors
  logic v1_r;
  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [COORD_WIDTH:0] dax, day, dbx, dby;
  always_comb begin
    dax = {in_ch.arm1_x[COORD_WIDTH-1], in_ch.arm1_x}
        - {in_ch.vertex_x[COORD_WIDTH-1], in_ch.vertex_x};
    day = {in_ch.arm1_y[COORD_WIDTH-1], in_ch.arm1_y}
        - {in_ch.vertex_y[COORD_WIDTH-1], in_ch.vertex_y};
    dbx = {in_ch.arm2_x[COORD_WIDTH-1], in_ch.arm2_x}
        - {in_ch.vertex_x[COORD_WIDTH-1], in_ch.vertex_x};
    dby = {in_ch.arm2_y[COORD_WIDTH-1], in_ch.arm2_y}
        - {in_ch.vertex_y[COORD_WIDTH-1], in_ch.vertex_y};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ch.valid;
    if (adv) begin
      ax_r <= DW'(dax >>> DS);
      ay_r <= DW'(day >>> DS);
      bx_r <= DW'(dbx >>> DS);
      by_r <= DW'(dby >>> DS);
    end
  end

  // stage 2: products
  logic v2_r;
  logic signed [2*DW-1:0] p_xx_r, p_yy_r, p_xy_r, p_yx_r, p_aa_r, p_ab_r, p_ba_r, p_bb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      p_xx_r <= ax_r * bx_r;
      p_yy_r <= ay_r * by_r;
      p_xy_r <= ax_r * by_r;
      p_yx_r <= ay_r * bx_r;
      p_aa_r <= ax_r * ax_r;
      p_ab_r <= ay_r * ay_r;
      p_ba_r <= bx_r * bx_r;
      p_bb_r <= by_r * by_r;
    end
  end

  // stage 3: sums, degeneracy, CORDIC setup
  localparam int SW = 2 * DW + 1;
  logic v3_r, dg3_r;
  logic signed [CW-1:0] x3_r, y3_r;
  logic signed [vao_pkg::ZW-1:0] z3_r;
  logic signed [SW-1:0] dot, crs, acrs;
  logic [SW+LS-1:0] l1, l2;
  logic dg;
  always_comb begin
    dot  = SW'(p_xx_r) + SW'(p_yy_r);
    crs  = SW'(p_xy_r) - SW'(p_yx_r);
    acrs = crs[SW-1] ? -crs : crs;
    l1   = (SW+LS)'(SW'(p_aa_r) + SW'(p_ab_r)) << LS;
    l2   = (SW+LS)'(SW'(p_ba_r) + SW'(p_bb_r)) << LS;
    dg   = (l1 == '0) || (l2 == '0) || (l1 < (SW+LS)'(minlen_r))
        || (l2 < (SW+LS)'(minlen_r));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      dg3_r <= dg;
      if (dot[SW-1]) begin
        x3_r <= CW'(acrs);
        y3_r <= CW'(-dot);
        z3_r <= vao_pkg::DEG_90;
      end else begin
        x3_r <= CW'(dot);
        y3_r <= CW'(acrs);
        z3_r <= '0;
      end
    end
  end

  // stages 4..7: normalise, shift search 32/16/8/4 then 2/1 folded into last
  logic vn_r [4];
  logic signed [CW-1:0] xn_r [4], yn_r [4];
  logic signed [vao_pkg::ZW-1:0] zn_r [4];
  logic dgn_r [4];
  localparam int SH [4] = '{32, 16, 8, 4};

  for (genvar k = 0; k < 4; k++) begin : g_norm
    logic signed [CW-1:0] xi, yi, xo, yo;
    logic signed [vao_pkg::ZW-1:0] zi;
    logic vi, di;
    logic [CW-1:0] m;
    if (k == 0) begin : g_src
      assign xi = x3_r;
      assign yi = y3_r;
      assign zi = z3_r;
      assign vi = v3_r;
      assign di = dg3_r;
    end else begin : g_src
      assign xi = xn_r[k-1];
      assign yi = yn_r[k-1];
      assign zi = zn_r[k-1];
      assign vi = vn_r[k-1];
      assign di = dgn_r[k-1];
    end
    always_comb begin
      xo = xi; yo = yi;
      m = xi | yi;
      if (m != '0 && (m >> (vao_pkg::NORM_BIT + 1 - SH[k])) == '0) begin
        xo = xo <<< SH[k]; yo = yo <<< SH[k];
      end
      if (k == 3) begin
        for (int j = 2; j >= 1; j = j / 2) begin
          m = xo | yo;
          if (m != '0 && (m >> (vao_pkg::NORM_BIT + 1 - j)) == '0) begin
            xo = xo <<< j; yo = yo <<< j;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vn_r[k] <= 1'b0;
      else if (adv) vn_r[k] <= vi;
      if (adv) begin
        xn_r[k] <= xo; yn_r[k] <= yo; zn_r[k] <= zi; dgn_r[k] <= di;
      end
    end
  end

  // CORDIC stages
  logic             cv [vao_pkg::STEPS+1];
  vao_pkg::cordic_t cd [vao_pkg::STEPS+1];
  assign cv[0] = vn_r[3];
  assign cd[0] = '{x: xn_r[3], y: yn_r[3], z: zn_r[3], degen: dgn_r[3]};
  for (genvar s = 0; s < vao_pkg::STEPS; s++) begin : g_cordic
    vao_cordic_stage #(.STEP(s)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_in(cv[s]), .d_in(cd[s]), .vld_r(cv[s+1]), .d_r(cd[s+1])
    );
  end

  // output: clamp and round
  logic signed [vao_pkg::ZW-1:0] zc, zr;
  logic [vao_pkg::ANGLE_W-1:0] ang;
  logic out_v_r, out_dg_r;
  logic [vao_pkg::ANGLE_W-1:0] out_ang_r;
  always_comb begin
    zc = cd[vao_pkg::STEPS].z;
    if (zc < 0) zc = '0;
    if (zc > vao_pkg::DEG_180) zc = vao_pkg::DEG_180;
    zr  = zc + vao_pkg::ZW'(4096);
    ang = zr[13 +: vao_pkg::ANGLE_W];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= cv[vao_pkg::STEPS];
    if (adv) begin
      out_dg_r  <= cd[vao_pkg::STEPS].degen;
      out_ang_r <= cd[vao_pkg::STEPS].degen ? vao_pkg::ANGLE_DEGEN : ang;
    end
  end
  assign out_ch.valid         = out_v_r;
  assign out_ch.angle_degrees = out_ang_r;
  assign out_ch.degenerate    = out_dg_r;
endmodule

// File: rtl/vao_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vao_cordic_stage
// One registered vectoring CORDIC rotation with a fixed shift.
// ----------------------------------------------------------------------------
module vao_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             vld_in,
  input  vao_pkg::cordic_t d_in,
  output logic             vld_r,
  output vao_pkg::cordic_t d_r
);
  vao_pkg::cordic_t d_nxt;
  logic signed [vao_pkg::CW-1:0] dx, dy;
  logic signed [vao_pkg::ZW-1:0] t;

  always_comb begin
    dx = d_in.x >>> STEP;
    dy = d_in.y >>> STEP;
    t  = vao_pkg::atan_q20(5'(STEP));
    d_nxt = d_in;
    if (!d_in.y[vao_pkg::CW-1]) begin
      d_nxt.x = d_in.x + dy;
      d_nxt.y = d_in.y - dx;
      d_nxt.z = d_in.z + t;
    end else begin
      d_nxt.x = d_in.x - dy;
      d_nxt.y = d_in.y + dx;
      d_nxt.z = d_in.z - t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
    if (adv) begin
      d_r <= d_nxt;
    end
  end
endmodule

// File: tb/sv/vao_tb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vao_tb_checker
// Watches the point and angle channels, predicts each angle and compares.
// ----------------------------------------------------------------------------
module vao_tb_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [vao_pkg::MINLEN_W-1:0] cfg_wdata,
  vao_in_if                            in_ch,
  vao_out_if                           out_ch,
  output int                           fail_count,
  output int                           pending
);
  typedef struct packed {
    logic [vao_pkg::ANGLE_W-1:0] angle;
    logic                        degen;
  } angle_res_t;

  angle_res_t                   angle_q[$];
  logic [vao_pkg::MINLEN_W-1:0] min_len_sq;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic angle_res_t vertex_angle(
      logic signed [15:0] ax, ay, vx, vy, bx, by, logic [vao_pkg::MINLEN_W-1:0] min_len);
    angle_res_t r;
    longint d1x, d1y, d2x, d2y, dot, crs, l1, l2, x, y, z, top, dx, dy;
    d1x = longint'(ax) - longint'(vx);
    d1y = longint'(ay) - longint'(vy);
    d2x = longint'(bx) - longint'(vx);
    d2y = longint'(by) - longint'(vy);
    dot = d1x * d2x + d1y * d2y;
    crs = d1x * d2y - d1y * d2x;
    l1  = d1x * d1x + d1y * d1y;
    l2  = d2x * d2x + d2y * d2y;
    if (l1 == 0 || l2 == 0 || l1 < longint'(min_len) || l2 < longint'(min_len)) begin
      r.angle = vao_pkg::ANGLE_DEGEN;
      r.degen = 1'b1;
      return r;
    end
    if (crs < 0) crs = -crs;
    if (dot < 0) begin
      x = crs; y = -dot; z = longint'(vao_pkg::DEG_90);
    end else begin
      x = dot; y = crs; z = 0;
    end
    top = (x > y) ? x : y;
    while (top != 0 && top < (64'sd1 <<< vao_pkg::NORM_BIT)) begin
      x = x <<< 1; y = y <<< 1; top = top <<< 1;
    end
    for (int i = 0; i < vao_pkg::STEPS; i++) begin
      dx = shr_floor(x, i);
      dy = shr_floor(y, i);
      if (y >= 0) begin
        x = x + dy; y = y - dx; z = z + longint'(vao_pkg::atan_q20(5'(i)));
      end else begin
        x = x - dy; y = y + dx; z = z - longint'(vao_pkg::atan_q20(5'(i)));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(vao_pkg::DEG_180)) z = longint'(vao_pkg::DEG_180);
    r.angle = vao_pkg::ANGLE_W'((z + (64'sd1 <<< 12)) >>> 13);
    r.degen = 1'b0;
    return r;
  endfunction

  assign pending = angle_q.size();

  always @(posedge clk) begin
    angle_res_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      min_len_sq <= 16'd1;
      fail_count <= 0;
    end else begin
      if (cfg_we) min_len_sq <= cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        angle_q.push_back(vertex_angle(in_ch.arm1_x, in_ch.arm1_y, in_ch.vertex_x,
                                       in_ch.vertex_y, in_ch.arm2_x, in_ch.arm2_y,
                                       min_len_sq));
      if (out_ch.valid && out_ch.ready) begin
        if (angle_q.size() == 0) begin
          $error("result with no request outstanding");
          errs = errs + 1;
        end else begin
          want = angle_q.pop_front();
          if (out_ch.angle_degrees !== want.angle) begin
            $error("angle_degrees: expected %0d, got %0d", want.angle,
                   out_ch.angle_degrees);
            errs = errs + 1;
          end
          if (out_ch.degenerate !== want.degen) begin
            $error("degenerate: expected %0d, got %0d", want.degen, out_ch.degenerate);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// File: tb/sv/vertex_angle_of_three_points_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_angle_of_three_points_tb
// Directed and random point triples under several minimum lengths, with
// random gaps and a long output stall; a checker compares every angle.
// ----------------------------------------------------------------------------
module vertex_angle_of_three_points_tb;
  localparam int LATENCY = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [vao_pkg::MINLEN_W-1:0] cfg_wdata = '0;
  int fail_count, pending;
  bit stall_long = 1'b0;
  bit sending_done = 1'b0;

  vao_in_if  in_ch ();
  vao_out_if out_ch ();

  vertex_angle_of_three_points DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  vao_tb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.arm1_x = '0; in_ch.arm1_y = '0;
    in_ch.vertex_x = '0; in_ch.vertex_y = '0;
    in_ch.arm2_x = '0; in_ch.arm2_y = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // receiver: random back-pressure, plus one long hold-off
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (stall_long) begin
        out_ch.ready <= 1'b0;
        for (int i = 0; i < 200; i++) @(posedge clk);
        stall_long = 1'b0;
      end
      n = sending_done ? 0 : gap_len();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_request(logic [15:0] ax, ay, vx, vy, bx, by, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.arm1_x <= ax; in_ch.arm1_y <= ay;
    in_ch.vertex_x <= vx; in_ch.vertex_y <= vy;
    in_ch.arm2_x <= bx; in_ch.arm2_y <= by;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_and_config(logic [vao_pkg::MINLEN_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8) - 4);
      2: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [15:0] vx, vy;
    int m;
    for (int k = 0; k < count; k++) begin
      m = $urandom_range(0, 9);
      if (m < 5) m = 0; else if (m < 7) m = 3; else if (m < 9) m = 1; else m = 2;
      vx = rnd_coord(m); vy = rnd_coord(m);
      case ($urandom_range(0, 9))
        0: send_request(vx, vy, vx, vy, rnd_coord(m), rnd_coord(m), 1'b1);
        1: send_request(rnd_coord(m), rnd_coord(m), vx, vy,
                        vx + 16'($urandom_range(0, 2)), vy, 1'b1);
        default: send_request(rnd_coord(m), rnd_coord(m), vx, vy,
                              rnd_coord(m), rnd_coord(m), 1'b1);
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, right/straight/zero angles, short and zero arms
    send_request(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
    send_request(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    send_request(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_request(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_request(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 1'b0);
    send_request(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h2000, 16'h0000, 1'b0);
    send_request(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_request(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b0);
    send_request(16'h1234, 16'h5678, 16'h1234, 16'h5678, 16'h0100, 16'h0200, 1'b0);
    send_request(16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0300, 16'h0400, 1'b0);
    send_request(16'h4000, 16'h0001, 16'h0000, 16'h0000, 16'h4000, 16'hFFFF, 1'b0);
    send_request(16'hC000, 16'h0001, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b0);
    send_request(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 1'b0);
    send_request(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'hAAAA, 16'h5555, 1'b0);

    random_phase(120);

    // long output stall while requests keep coming
    stall_long = 1'b1;
    random_phase(60);

    drain_and_config(16'd0);
    send_request(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b0);
    send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b0);
    random_phase(60);

    drain_and_config(16'hFFFF);
    send_request(16'h00FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 1'b0);
    send_request(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 1'b0);
    random_phase(80);

    drain_and_config(16'd40);
    send_request(16'h0006, 16'h0002, 16'h0000, 16'h0000, 16'h0002, 16'h0006, 1'b0);
    random_phase(80);

    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
